// File: hw/rtl/srp_pkg.sv
package srp_pkg;

    // Width of the per-relation singleton count and of the running total
    localparam int SINGLES_W = 6;
    localparam int TOTAL_W   = 32;
    localparam logic [SINGLES_W-1:0] SINGLES_MAX = 6'd63;

    // Operation codes carried with each ideal
    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_CLOSE,
        ST_WALK,
        ST_EMIT
    } t_state;

    // Commands to the relation buffer
    typedef struct packed {
        logic probe;   // register match flags against the incoming ideal
        logic append;  // store the ideal at the fill position
        logic shift;   // drop the head entry, advance the rest
        logic clear;   // empty the buffer
    } t_buf_ctrl;

endpackage

// File: hw/rtl/srp_relbuf.sv
module srp_relbuf #(
    parameter int IDEAL_BITS = 16,
    parameter int MAX_IDEALS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srp_pkg::t_buf_ctrl    i_ctrl,
    input  logic [IDEAL_BITS-1:0] i_id,
    output logic                  o_hit,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [IDEAL_BITS-1:0] o_head
);
    import srp_pkg::*;

    localparam int IDX_W  = (MAX_IDEALS > 1) ? $clog2(MAX_IDEALS) : 1;
    localparam int FILL_W = $clog2(MAX_IDEALS + 1);
    localparam logic [FILL_W-1:0] FillMax = FILL_W'(MAX_IDEALS);

    logic [IDEAL_BITS-1:0] r_entry [MAX_IDEALS];
    logic [FILL_W-1:0]     r_fill;
    logic [MAX_IDEALS-1:0] r_match;
    logic [MAX_IDEALS-1:0] n_match;

    // Compare every occupied entry against the probe in parallel
    always_comb begin
        for (int i = 0; i < MAX_IDEALS; i++) begin
            n_match[i] = (FILL_W'(i) < r_fill) && (r_entry[i] == i_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_match <= '0;
        end else begin
            if (i_ctrl.probe) begin
                r_match <= n_match;
            end
            if (i_ctrl.clear) begin
                r_fill <= '0;
            end else if (i_ctrl.append && !o_full) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_ctrl.shift && !o_empty) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && !o_full) begin
            r_entry[r_fill[IDX_W-1:0]] <= i_id;
        end else if (i_ctrl.shift) begin
            for (int i = 0; i < MAX_IDEALS - 1; i++) begin
                r_entry[i] <= r_entry[i+1];
            end
        end
    end

    assign o_hit   = |r_match;
    assign o_full  = (r_fill == FillMax);
    assign o_empty = (r_fill == '0);
    assign o_head  = r_entry[0];

endmodule

// File: hw/rtl/singleton_relation_pruner.sv
// Singleton relation pruner.
// Input channel (i_in_valid / o_in_ready) takes one word per ideal: the
// operation (count or filter pass), the ideal number and a last-of-relation
// flag. Output channel (o_out_valid / i_out_ready) gives one word per
// relation, on its last ideal: whether the relation went to excess, its
// singleton count, the running removed total, the pruning state and the
// buffer overflow flag. The target is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while the block is idle; it is not enforced.
// An ideal that does not end a relation gets a table read, then, on a count
// pass, a read-modify-write of the occurrence table. When a closing ideal
// removes the relation, the block walks the relation buffer and decrements one
// table entry per cycle through the table's single read and single write port.
// Reset: the occurrence table is cleared by a pass over every entry, one entry
// per cycle, during which o_in_ready stays low. Pruning comes up active and the
// target comes up zero.
// A stalled receiver holds the result in the output register; the block
// still finishes the next relation's ideals and waits only to emit its result.
module singleton_relation_pruner #(
    parameter int IDEAL_BITS = 16,
    parameter int COUNT_BITS = 16,
    parameter int MAX_IDEALS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // ideal words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_ideal_id,
    input  logic        i_last_of_relation,
    // per-relation result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_moved_to_excess,
    output logic [5:0]  o_singles_found,
    output logic [31:0] o_removed_total,
    output logic        o_still_pruning,
    output logic        o_overflow,
    // target register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import srp_pkg::*;

    localparam int TABLE_DEPTH = 1 << IDEAL_BITS;
    localparam int ID_USED     = (IDEAL_BITS < 16) ? IDEAL_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    // Occurrence table: one read port, one write port, registered read
    logic [COUNT_BITS-1:0] r_table [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] r_tab_rdata;

    t_state r_state;
    t_state n_state;

    // Latched word
    logic                  r_op;
    logic                  r_last;
    logic [IDEAL_BITS-1:0] r_id;

    // Relation and pruning state
    logic [SINGLES_W-1:0]  r_singles;
    logic                  r_overflow;
    logic                  r_moved;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_pruning;
    logic [TOTAL_W-1:0]    r_target;
    logic [IDEAL_BITS-1:0] r_clr_addr;
    logic                  r_wr_pend;
    logic [IDEAL_BITS-1:0] r_wr_addr;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_moved;
    logic [SINGLES_W-1:0]  r_out_singles;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_pruning;
    logic                  r_out_overflow;

    // Control decode
    logic                  w_accept;
    logic                  w_in_ready;
    logic                  w_tab_re;
    logic [IDEAL_BITS-1:0] w_tab_raddr;
    logic                  w_tab_we;
    logic [IDEAL_BITS-1:0] w_tab_waddr;
    logic [COUNT_BITS-1:0] w_tab_wdata;
    t_buf_ctrl             w_buf_ctrl;
    logic                  w_emit_go;

    logic [IDEAL_BITS-1:0] w_id;
    logic                  w_buf_hit;
    logic                  w_buf_full;
    logic                  w_buf_empty;
    logic [IDEAL_BITS-1:0] w_buf_head;
    logic                  w_new;
    logic                  w_move;
    logic [TOTAL_W:0]      w_sum;
    logic                  w_prune_next;
    logic [COUNT_BITS-1:0] w_inc;
    logic [COUNT_BITS-1:0] w_dec;

    assign w_id     = IDEAL_BITS'(i_ideal_id[ID_USED-1:0]);
    assign w_accept = i_in_valid && w_in_ready;

    // Saturating count updates on the table read data
    assign w_inc = (r_tab_rdata == CountMax) ? r_tab_rdata : r_tab_rdata + CountOne;
    assign w_dec = (r_tab_rdata == '0) ? r_tab_rdata : r_tab_rdata - CountOne;

    // A distinct ideal that still fits in the buffer
    assign w_new  = !w_buf_hit && !w_buf_full;
    assign w_move = (r_op == OP_FILTER) && r_pruning && (r_singles > SINGLES_W'(1));
    assign w_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(r_singles);

    assign w_prune_next = r_pruning && !(r_moved && (r_total >= r_target));
    assign w_emit_go    = !r_out_valid || i_out_ready;

    srp_relbuf #(
        .IDEAL_BITS (IDEAL_BITS),
        .MAX_IDEALS (MAX_IDEALS)
    ) u_relbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_buf_ctrl),
        .i_id    ((r_state == ST_IDLE) ? w_id : r_id),
        .o_hit   (w_buf_hit),
        .o_full  (w_buf_full),
        .o_empty (w_buf_empty),
        .o_head  (w_buf_head)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = r_last ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE: begin
                n_state = w_move ? ST_WALK : ST_EMIT;
            end
            ST_WALK: begin
                // the final pending write retires in the cycle the buffer runs empty
                if (w_buf_empty) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State outputs: table ports and buffer commands
    always_comb begin
        w_in_ready  = 1'b0;
        w_tab_re    = 1'b0;
        w_tab_raddr = w_id;
        w_tab_we    = 1'b0;
        w_tab_waddr = r_id;
        w_tab_wdata = w_inc;
        w_buf_ctrl  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_tab_we    = 1'b1;
                w_tab_waddr = r_clr_addr;
                w_tab_wdata = '0;
            end
            ST_IDLE: begin
                w_in_ready       = 1'b1;
                w_tab_re         = w_accept;
                w_buf_ctrl.probe = w_accept;
            end
            ST_UPDATE: begin
                w_tab_we          = w_new && (r_op == OP_COUNT);
                w_buf_ctrl.append = w_new;
            end
            ST_CLOSE: begin
            end
            ST_WALK: begin
                w_tab_re         = !w_buf_empty;
                w_tab_raddr      = w_buf_head;
                w_buf_ctrl.shift = !w_buf_empty;
                w_tab_we         = r_wr_pend;
                w_tab_waddr      = r_wr_addr;
                w_tab_wdata      = w_dec;
            end
            ST_EMIT: begin
                w_buf_ctrl.clear = w_emit_go;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_table[w_tab_waddr] <= w_tab_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_re) begin
            r_tab_rdata <= r_table[w_tab_raddr];
        end
    end

    // Control and relation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_singles   <= '0;
            r_overflow  <= 1'b0;
            r_moved     <= 1'b0;
            r_total     <= '0;
            r_pruning   <= 1'b1;
            r_target    <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDEAL_BITS'(1);
            end
            if (r_state == ST_UPDATE) begin
                if (w_new && (r_op == OP_FILTER) && (r_tab_rdata == CountOne)
                        && (r_singles != SINGLES_MAX)) begin
                    r_singles <= r_singles + SINGLES_W'(1);
                end
                if (!w_buf_hit && w_buf_full) begin
                    r_overflow <= 1'b1;
                end
            end
            if (r_state == ST_CLOSE) begin
                r_moved <= w_move;
                if (w_move) begin
                    r_total <= w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
                end
            end
            // track the decrement that follows each walk read in the next cycle
            r_wr_pend <= (r_state == ST_WALK) && !w_buf_empty;
            if (r_state == ST_EMIT && w_emit_go) begin
                r_pruning   <= w_prune_next;
                r_singles   <= '0;
                r_overflow  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_last <= i_last_of_relation;
            r_id   <= w_id;
        end
        if (r_state == ST_WALK && !w_buf_empty) begin
            r_wr_addr <= w_buf_head;
        end
        if (r_state == ST_EMIT && w_emit_go) begin
            r_out_moved    <= r_moved && (r_op == OP_FILTER);
            r_out_singles  <= (r_op == OP_FILTER) ? r_singles : '0;
            r_out_total    <= r_total;
            r_out_pruning  <= w_prune_next;
            r_out_overflow <= r_overflow;
        end
    end

    assign o_in_ready        = w_in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_moved_to_excess = r_out_moved;
    assign o_singles_found   = r_out_singles;
    assign o_removed_total   = r_out_total;
    assign o_still_pruning   = r_out_pruning;
    assign o_overflow        = r_out_overflow;

endmodule
